/* src/ffra_pkg.sv */
// shared widths for the first-fit run allocator
package ffra_pkg;

   localparam int ReqCountW  = 7;
   localparam int SlotFieldW = 6;

endpackage

/* src/ffra_if.sv */
// request and response channel interfaces of the first-fit run allocator
interface ffra_req_if;
   import ffra_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ReqCountW-1:0] request_count;

   modport source (output valid, output request_count, input ready);
   modport sink   (input valid, input request_count, output ready);
endinterface

interface ffra_rsp_if;
   import ffra_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  granted;
   logic [SlotFieldW-1:0] first_slot;

   modport source (output valid, output granted, output first_slot, input ready);
   modport sink   (input valid, input granted, input first_slot, output ready);
endinterface

/* src/ffra_ram.sv */
// generic single-write, single-read ram with registered read data
module ffra_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* src/first_fit_run_allocator_top.sv */
// first-fit contiguous run allocator over a slot occupancy ram
// After reset the block clears the occupancy ram slot by slot and accepts
// no item meanwhile. A request for zero slots, or for more than SLOT_COUNT,
// goes straight to the finish state, which loads its result into the output
// register once that register is free. Any other request scans the ram from
// slot 0 through its single read port, one slot a cycle, until a free run of
// the requested length ends or the last slot is checked; if a run is found it
// then writes the granted slots one a cycle, and in either case it then loads
// the result register once that register is free. One item is worked at a
// time; the next is accepted once the result has been loaded into the output
// register.
module first_fit_run_allocator_top #(
   parameter int SLOT_COUNT = 64
) (
   input logic         clock,
   input logic         reset,
   ffra_req_if.sink    req_chan,
   ffra_rsp_if.source  rsp_chan
);
   import ffra_pkg::*;

   localparam int AddrW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CntW     = $clog2(SLOT_COUNT + 1);
   localparam int WideW    = (CntW > ReqCountW) ? CntW : ReqCountW;
   localparam int SlotExtW = (AddrW > SlotFieldW) ? AddrW : SlotFieldW;

   localparam logic [AddrW-1:0] LastAddr      = AddrW'(SLOT_COUNT - 1);
   localparam logic [CntW-1:0]  SlotTotal     = CntW'(SLOT_COUNT);
   localparam logic [WideW-1:0] SlotTotalWide = WideW'(SLOT_COUNT);

   localparam logic [2:0] StClear  = 3'd0;
   localparam logic [2:0] StIdle   = 3'd1;
   localparam logic [2:0] StScan   = 3'd2;
   localparam logic [2:0] StMark   = 3'd3;
   localparam logic [2:0] StFinish = 3'd4;

   logic [2:0]            state_ff,       state_in;
   logic [AddrW-1:0]      clr_addr_ff,    clr_addr_in;
   logic [CntW-1:0]       want_ff,        want_in;
   logic [CntW-1:0]       issue_ff,       issue_in;
   logic                  rd_pend_ff,     rd_pend_in;
   logic [AddrW-1:0]      chk_idx_ff,     chk_idx_in;
   logic [CntW-1:0]       run_ff,         run_in;
   logic [AddrW-1:0]      mark_addr_ff,   mark_addr_in;
   logic [CntW-1:0]       mark_left_ff,   mark_left_in;
   logic                  res_granted_ff, res_granted_in;
   logic [AddrW-1:0]      res_start_ff,   res_start_in;
   logic                  rsp_valid_ff,   rsp_valid_in;
   logic                  rsp_granted_ff, rsp_granted_in;
   logic [SlotFieldW-1:0] rsp_slot_ff,    rsp_slot_in;

   logic                  req_accept;
   logic [WideW-1:0]      want_wide;
   logic [CntW-1:0]       run_inc;
   logic [AddrW-1:0]      start_calc;
   logic [SlotExtW-1:0]   start_ext;

   logic                  ram_wr_en;
   logic [AddrW-1:0]      ram_wr_addr;
   logic [0:0]            ram_wr_data;
   logic                  ram_rd_en;
   logic [AddrW-1:0]      ram_rd_addr;
   logic [0:0]            ram_rd_data;

   ffra_ram #(
      .WIDTH (1),
      .DEPTH (SLOT_COUNT)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready      = (state_ff == StIdle);
   assign req_accept          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.granted    = rsp_granted_ff;
   assign rsp_chan.first_slot = rsp_slot_ff;

   assign want_wide  = WideW'(req_chan.request_count);
   assign run_inc    = run_ff + CntW'(1);
   assign start_calc = AddrW'(CntW'(chk_idx_ff) + CntW'(1) - want_ff);
   assign start_ext  = SlotExtW'(res_start_ff);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      want_in        = want_ff;
      issue_in       = issue_ff;
      rd_pend_in     = 1'b0;
      chk_idx_in     = chk_idx_ff;
      run_in         = run_ff;
      mark_addr_in   = mark_addr_ff;
      mark_left_in   = mark_left_ff;
      res_granted_in = res_granted_ff;
      res_start_in   = res_start_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_slot_in    = rsp_slot_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = clr_addr_ff;
      ram_wr_data    = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = issue_ff[AddrW-1:0];

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         StClear: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = 1'b0;
            clr_addr_in = clr_addr_ff + AddrW'(1);
            if (clr_addr_ff == LastAddr) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (req_accept) begin
               if (want_wide == '0) begin
                  res_granted_in = 1'b1;
                  res_start_in   = '0;
                  state_in       = StFinish;
               end else if (want_wide > SlotTotalWide) begin
                  res_granted_in = 1'b0;
                  res_start_in   = '0;
                  state_in       = StFinish;
               end else begin
                  want_in  = CntW'(want_wide);
                  issue_in = '0;
                  run_in   = '0;
                  state_in = StScan;
               end
            end
         end
         StScan: begin
            if (issue_ff != SlotTotal) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = issue_ff[AddrW-1:0];
               issue_in    = issue_ff + CntW'(1);
               chk_idx_in  = issue_ff[AddrW-1:0];
               rd_pend_in  = 1'b1;
            end
            if (rd_pend_ff) begin
               if (ram_rd_data[0]) begin
                  run_in = '0;
               end else begin
                  run_in = run_inc;
               end
               if (!ram_rd_data[0] && (run_inc == want_ff)) begin
                  mark_addr_in   = start_calc;
                  mark_left_in   = want_ff;
                  res_granted_in = 1'b1;
                  res_start_in   = start_calc;
                  rd_pend_in     = 1'b0;
                  state_in       = StMark;
               end else if (chk_idx_ff == LastAddr) begin
                  res_granted_in = 1'b0;
                  res_start_in   = '0;
                  rd_pend_in     = 1'b0;
                  state_in       = StFinish;
               end
            end
         end
         StMark: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = mark_addr_ff;
            ram_wr_data  = 1'b1;
            mark_addr_in = mark_addr_ff + AddrW'(1);
            mark_left_in = mark_left_ff - CntW'(1);
            if (mark_left_ff == CntW'(1)) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_slot_in    = start_ext[SlotFieldW-1:0];
               state_in       = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StClear;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff        <= want_in;
      issue_ff       <= issue_in;
      chk_idx_ff     <= chk_idx_in;
      run_ff         <= run_in;
      mark_addr_ff   <= mark_addr_in;
      mark_left_ff   <= mark_left_in;
      res_granted_ff <= res_granted_in;
      res_start_ff   <= res_start_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   // map is only written while clearing or marking a granted run
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == StClear) || (state_ff == StMark))
      else $error("occupancy ram written outside clear or mark");

   // a run being marked always has slots left to write
   a_mark_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StMark) |-> (mark_left_ff != '0))
      else $error("mark phase with no slots left");

   // one item at a time: no new accept right after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_chan.ready)
      else $error("request accepted while one is in flight");

   // a refused request reports slot zero
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_granted_ff) |-> (rsp_slot_ff == '0))
      else $error("refused item with nonzero first slot");

endmodule

/* sim/first_fit_run_allocator_top_tb.sv */
// self-checking testbench of the first-fit run allocator: directed table, then random requests
module first_fit_run_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ffra_pkg::*;

   localparam int SlotCount     = 64;
   localparam int DirectedItems = 13;
   localparam int RandomItems   = 700;
   localparam int TotalItems    = DirectedItems + RandomItems;
   localparam int QuietTail     = 100;
   localparam int LongHoldAt    = 150;
   localparam int LongHoldLen   = 500;
   localparam int PauseAt       = 400;
   localparam int DrainCycles   = 2 * SlotCount + 20;
   localparam int CycleLimit    = 600000;

   typedef logic [ReqCountW-1:0] count_type;

   typedef struct packed {
      logic                  granted;
      logic [SlotFieldW-1:0] first_slot;
   } grant_type;

   typedef struct packed {
      count_type count;
      bit        fixed;
      grant_type outcome;
   } row_type;

   // fixed rows carry their result, the rest go through the predictor
   row_type plan [0:DirectedItems-1] = '{
      '{7'd0,   1'b1, '{1'b1, 6'd0}},
      '{7'd127, 1'b1, '{1'b0, 6'd0}},
      '{7'd65,  1'b1, '{1'b0, 6'd0}},
      '{7'd1,   1'b1, '{1'b1, 6'd0}},
      '{7'd64,  1'b1, '{1'b0, 6'd0}},
      '{7'd2,   1'b0, '{1'b0, 6'd0}},
      '{7'd0,   1'b1, '{1'b1, 6'd0}},
      '{7'd3,   1'b0, '{1'b0, 6'd0}},
      '{7'd62,  1'b0, '{1'b0, 6'd0}},
      '{7'd96,  1'b1, '{1'b0, 6'd0}},
      '{7'd5,   1'b0, '{1'b0, 6'd0}},
      '{7'd16,  1'b0, '{1'b0, 6'd0}},
      '{7'd1,   1'b0, '{1'b0, 6'd0}}
   };

   logic clock = 1'b0;
   logic reset;

   logic [SlotCount-1:0] taken_map = '0;
   grant_type            pending_grants [$];
   int                   items_sent     = 0;
   int                   results_seen   = 0;
   int                   grants_seen    = 0;
   int                   refusals_seen  = 0;
   int                   errors         = 0;
   int                   cycle_count    = 0;
   bit                   sender_done    = 1'b0;

   ffra_req_if req_if ();
   ffra_rsp_if rsp_if ();

   first_fit_run_allocator_top #(
      .SLOT_COUNT (SlotCount)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, pending_grants.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // lowest free run of the requested length, marked taken when found
   function automatic grant_type claim_run(input count_type count);
      grant_type res;
      int        run;
      int        start;
      res   = '0;
      run   = 0;
      start = -1;
      if (count == 0) begin
         res.granted = 1'b1;
         return res;
      end
      if (count <= SlotCount) begin
         for (int i = 0; i < SlotCount && start < 0; i++) begin
            if (taken_map[i]) begin
               run = 0;
            end else begin
               run++;
               if (run == count) start = i + 1 - count;
            end
         end
      end
      if (start >= 0) begin
         for (int i = start; i < start + count; i++) taken_map[i] = 1'b1;
         res.granted    = 1'b1;
         res.first_slot = start[SlotFieldW-1:0];
      end
      return res;
   endfunction

   function automatic count_type pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return '0;
      if (roll < 70) return count_type'($urandom_range(1, 3));
      if (roll < 85) return count_type'($urandom_range(4, SlotCount));
      return count_type'($urandom_range(SlotCount + 1, 127));
   endfunction

   task automatic offer(input count_type count, input bit fixed, input grant_type typed);
      grant_type predicted;
      req_if.valid         <= 1'b1;
      req_if.request_count <= count;
      do @(posedge clock); while (!req_if.ready);
      predicted = claim_run(count);
      pending_grants.push_back(fixed ? typed : predicted);
      items_sent++;
   endtask

   task automatic idle_gap();
      int n;
      if (items_sent >= TotalItems - QuietTail || (items_sent / 120) % 4 == 3) return;
      if ($urandom_range(0, 3) != 0) return;
      n = $urandom_range(1, 12);
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      req_if.valid         <= 1'b0;
      req_if.request_count <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);
      foreach (plan[i]) begin
         offer(plan[i].count, plan[i].fixed, plan[i].outcome);
         idle_gap();
      end
      for (int i = 0; i < RandomItems; i++) begin
         // let everything drain once before carrying on
         if (items_sent == PauseAt) begin
            req_if.valid <= 1'b0;
            do @(posedge clock); while (pending_grants.size() != 0);
         end
         offer(pick_count(), 1'b0, '0);
         idle_gap();
      end
      req_if.valid <= 1'b0;
      sender_done = 1'b1;
   end

   initial begin
      int        hold_left;
      bit        held_long;
      grant_type actual;
      grant_type expected;
      hold_left = 0;
      held_long = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            actual = '{rsp_if.granted, rsp_if.first_slot};
            results_seen++;
            if (actual.granted === 1'b1) grants_seen++;
            else refusals_seen++;
            if (pending_grants.size() == 0) begin
               errors++;
               $display("%0t: unexpected item: expected none, actual granted %0b first_slot %0d",
                        $time, actual.granted, actual.first_slot);
            end else begin
               expected = pending_grants.pop_front();
               if (actual.granted !== expected.granted) begin
                  errors++;
                  $display("%0t: granted mismatch: expected %0b actual %0b",
                           $time, expected.granted, actual.granted);
               end
               if (actual.first_slot !== expected.first_slot) begin
                  errors++;
                  $display("%0t: first_slot mismatch: expected %0d actual %0d",
                           $time, expected.first_slot, actual.first_slot);
               end
            end
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!held_long && results_seen == LongHoldAt) begin
            // long back-pressure so the input side stalls
            held_long = 1'b1;
            hold_left = LongHoldLen - 1;
            rsp_if.ready <= 1'b0;
         end else if (results_seen < TotalItems - QuietTail && (results_seen / 100) % 4 != 3
                      && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 11);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (sender_done);
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("%0d requests (%0d from the table), %0d results checked: %0d granted, %0d refused",
               items_sent, DirectedItems, results_seen, grants_seen, refusals_seen);
      $display("%0d of %0d slots taken at the end, %0d mismatches",
               $countones(taken_map), SlotCount, errors);
      if (errors == 0 && pending_grants.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
